>>> sv/ikin_pkg.sv
// ----------------------------------------------------------------------------
// ikin_pkg
// Shared widths, constants, tables and helper functions of the arm solver.
// ----------------------------------------------------------------------------
package ikin_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int DIV_STEPS    = 30;
	localparam int SQRT_STEPS   = 31;

	localparam int CW  = 54;
	localparam int AW  = 20;
	localparam int TW  = 19;
	localparam int MW  = 29;
	localparam int RW  = 55;
	localparam int DW  = 53;
	localparam int NW  = 60;
	localparam int SQW = 61;
	localparam int QW  = 30;
	localparam int CV  = 32;
	localparam int SW  = 31;
	localparam int ZW  = 21;

	localparam logic signed [ZW-1:0] MOUNT_HEIGHT = '0;

	localparam logic signed [AW-1:0] PI_Q16 = 20'sd205887;
	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

	localparam logic signed [AW-1:0] ATAN_Q16 [0:23] = '{
		20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
		20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32,
		20'sd16, 20'sd8, 20'sd4, 20'sd2, 20'sd1, 20'sd0,
		20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0
	};

	typedef enum logic [2:0] {
		REG_UPPER_LINK = 3'd0,
		REG_LOWER_LINK = 3'd1,
		REG_BASE_MIN   = 3'd2,
		REG_BASE_MAX   = 3'd3,
		REG_SHLD_MIN   = 3'd4,
		REG_SHLD_MAX   = 3'd5,
		REG_ELBOW_MIN  = 3'd6,
		REG_ELBOW_MAX  = 3'd7
	} reg_index_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_REACH = 2'd1,
		STATUS_LIMIT = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [ZW-1:0] zeff;
		logic signed [TW-1:0] t1;
		logic signed [AW-1:0] a_plane;
		logic                 oor;
		logic                 cpos;
		logic                 cneg;
		logic                 nneg;
		logic signed [CV-1:0] c;
	} side_t;

	function automatic logic signed [TW-1:0] to_q13(input logic signed [ZW-1:0] v);
		logic signed [ZW:0] t;
		t = (ZW+1)'(v) + (ZW+1)'(4);
		return TW'(t >>> 3);
	endfunction

	function automatic logic [MW-1:0] gain(input logic [29:0] x);
		logic [59:0] p;
		p = 60'(x) * 60'(INV_GAIN_Q30);
		p = p + (60'(1) << 29);
		return MW'(p >> 30);
	endfunction

endpackage

>>> sv/ikin_cordic.sv
// ----------------------------------------------------------------------------
// ikin_cordic
// Pipelined vectoring CORDIC, one register stage per micro-rotation.
// ----------------------------------------------------------------------------
module ikin_cordic (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic signed [ikin_pkg::CW-1:0] in_x,
	input  logic signed [ikin_pkg::CW-1:0] in_y,
	input  ikin_pkg::side_t            in_side,
	output logic                       out_valid,
	output logic signed [ikin_pkg::CW-1:0] out_x,
	output logic signed [ikin_pkg::AW-1:0] out_z,
	output ikin_pkg::side_t            out_side
);
	import ikin_pkg::*;

	logic signed [CW-1:0] xs [0:CORDIC_STEPS];
	logic signed [CW-1:0] ys [0:CORDIC_STEPS];
	logic signed [AW-1:0] zs [0:CORDIC_STEPS];
	logic                 zero [0:CORDIC_STEPS];
	side_t                sd [0:CORDIC_STEPS];
	logic                 vs [0:CORDIC_STEPS];

	// pre-rotation into the right half plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vs[0] <= 1'b0;
		end else if (en) begin
			vs[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero[0] <= (in_x == '0) && (in_y == '0);
			sd[0]   <= in_side;
			if (in_x < 0) begin
				xs[0] <= -in_x;
				ys[0] <= -in_y;
				zs[0] <= (in_y >= 0) ? PI_Q16 : -PI_Q16;
			end else begin
				xs[0] <= in_x;
				ys[0] <= in_y;
				zs[0] <= '0;
			end
		end
	end

	for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vs[k] <= 1'b0;
			end else if (en) begin
				vs[k] <= vs[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero[k] <= zero[k-1];
				sd[k]   <= sd[k-1];
				if (ys[k-1] >= 0) begin
					xs[k] <= xs[k-1] + (ys[k-1] >>> (k-1));
					ys[k] <= ys[k-1] - (xs[k-1] >>> (k-1));
					zs[k] <= zs[k-1] + ATAN_Q16[k-1];
				end else begin
					xs[k] <= xs[k-1] - (ys[k-1] >>> (k-1));
					ys[k] <= ys[k-1] + (xs[k-1] >>> (k-1));
					zs[k] <= zs[k-1] - ATAN_Q16[k-1];
				end
			end
		end
	end

	assign out_valid = vs[CORDIC_STEPS];
	assign out_x     = xs[CORDIC_STEPS];
	assign out_z     = zero[CORDIC_STEPS] ? '0 : zs[CORDIC_STEPS];
	assign out_side  = sd[CORDIC_STEPS];

endmodule

>>> sv/ikin_div.sv
// ----------------------------------------------------------------------------
// ikin_div
// Pipelined restoring divider giving a 30-bit fraction, one bit per stage.
// ----------------------------------------------------------------------------
module ikin_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [ikin_pkg::RW-1:0]  in_rem,
	input  logic [ikin_pkg::DW-1:0]  den,
	input  ikin_pkg::side_t          in_side,
	output logic                     out_valid,
	output logic [ikin_pkg::QW-1:0]  out_q,
	output ikin_pkg::side_t          out_side
);
	import ikin_pkg::*;

	logic [RW-1:0] rem [0:DIV_STEPS];
	logic [QW-1:0] q   [0:DIV_STEPS];
	side_t         sd  [0:DIV_STEPS];
	logic          vs  [0:DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vs[0] <= 1'b0;
		end else if (en) begin
			vs[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem[0] <= in_rem;
			q[0]   <= '0;
			sd[0]  <= in_side;
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic [RW-1:0] sh;
		assign sh = rem[k-1] << 1;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vs[k] <= 1'b0;
			end else if (en) begin
				vs[k] <= vs[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd[k] <= sd[k-1];
				if (sh >= RW'(den)) begin
					rem[k] <= sh - RW'(den);
					q[k]   <= {q[k-1][QW-2:0], 1'b1};
				end else begin
					rem[k] <= sh;
					q[k]   <= {q[k-1][QW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vs[DIV_STEPS];
	assign out_q     = q[DIV_STEPS];
	assign out_side  = sd[DIV_STEPS];

endmodule

>>> sv/ikin_sqrt.sv
// ----------------------------------------------------------------------------
// ikin_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ikin_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [ikin_pkg::SQW-1:0] in_v,
	input  ikin_pkg::side_t          in_side,
	output logic                     out_valid,
	output logic [ikin_pkg::SW-1:0]  out_s,
	output ikin_pkg::side_t          out_side
);
	import ikin_pkg::*;

	logic [SQW-1:0] v   [0:SQRT_STEPS];
	logic [SQW-1:0] res [0:SQRT_STEPS];
	side_t          sd  [0:SQRT_STEPS];
	logic           vs  [0:SQRT_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vs[0] <= 1'b0;
		end else if (en) begin
			vs[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v[0]   <= in_v;
			res[0] <= '0;
			sd[0]  <= in_side;
		end
	end

	for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_step
		localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 1 - 2 * (k - 1));
		logic [SQW-1:0] trial;
		assign trial = res[k-1] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vs[k] <= 1'b0;
			end else if (en) begin
				vs[k] <= vs[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd[k] <= sd[k-1];
				if (v[k-1] >= trial) begin
					v[k]   <= v[k-1] - trial;
					res[k] <= (res[k-1] >> 1) + BIT;
				end else begin
					v[k]   <= v[k-1];
					res[k] <= res[k-1] >> 1;
				end
			end
		end
	end

	assign out_valid = vs[SQRT_STEPS];
	assign out_s     = SW'(res[SQRT_STEPS]);
	assign out_side  = sd[SQRT_STEPS];

endmodule

>>> sv/rrr_arm_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// rrr_arm_inverse_kinematics
// Elbow-up joint angles for a base-yaw arm with two planar links.
// ----------------------------------------------------------------------------
// The slave stream takes one target point per item, the master stream
// returns base, shoulder and elbow angles in Q.13 radians with a status
// code in tuser. The cfg channel writes link lengths and joint limits; it is
// always ready, and the user must write it only while no item is in flight,
// which the block does not check. The datapath is one pipeline: base CORDIC,
// gain, plane CORDIC, gain, reach test and elbow cosine numerator, a
// one-bit-per-stage divider, a one-bit-per-stage square root, then the elbow
// and offset CORDICs in parallel and the limit check. The depth is set by the
// 30 divider and 31 root stages and the three CORDIC chains. One item is
// accepted every cycle while the receiver does not stall the output.
// The whole pipeline advances together while the output register is empty
// or being taken; when the receiver stalls every stage holds its item.
// Reset clears all valid bits and loads the default lengths and limits.
// ----------------------------------------------------------------------------
module rrr_arm_inverse_kinematics (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // target_x, target_y, target_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // base_angle, shoulder_angle, elbow_angle
	output logic [1:0]  m_tuser,   // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_data
);
	import ikin_pkg::*;

	logic [17:0]        l1_q, l2_q;
	logic signed [16:0] bmin_q, bmax_q, smin_q, smax_q, emin_q, emax_q;
	logic [DW-1:0]      lsq_q, den_q;
	logic [25:0]        rmin_q;
	logic [26:0]        rmax_q;

	logic en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q   <= 18'd1600;
			l2_q   <= 18'd1600;
			bmin_q <= -17'sd51472;
			bmax_q <= 17'sd51472;
			smin_q <= -17'sd51472;
			smax_q <= 17'sd51472;
			emin_q <= -17'sd51472;
			emax_q <= 17'sd51472;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_UPPER_LINK: l1_q   <= cfg_data;
				REG_LOWER_LINK: l2_q   <= cfg_data;
				REG_BASE_MIN:   bmin_q <= cfg_data[16:0];
				REG_BASE_MAX:   bmax_q <= cfg_data[16:0];
				REG_SHLD_MIN:   smin_q <= cfg_data[16:0];
				REG_SHLD_MAX:   smax_q <= cfg_data[16:0];
				REG_ELBOW_MIN:  emin_q <= cfg_data[16:0];
				REG_ELBOW_MAX:  emax_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// terms that depend on the link lengths only
	always_ff @(posedge clk) begin
		lsq_q  <= (DW'(l1_q) * DW'(l1_q) + DW'(l2_q) * DW'(l2_q)) << 16;
		den_q  <= (DW'(l1_q) * DW'(l2_q)) << 17;
		rmin_q <= (l1_q > l2_q) ? {l1_q - l2_q, 8'b0} : {l2_q - l1_q, 8'b0};
		rmax_q <= (27'(l1_q) + 27'(l2_q)) << 8;
	end

	// input unpacking
	logic signed [19:0]   in_x, in_y, in_z;
	side_t                in_side;

	assign in_x = s_tdata[19:0];
	assign in_y = s_tdata[39:20];
	assign in_z = s_tdata[59:40];

	always_comb begin
		in_side      = '0;
		in_side.zeff = ZW'(in_z) - MOUNT_HEIGHT;
	end

	assign s_tready = en;

	// base yaw
	logic                 cb_valid;
	logic signed [CW-1:0] cb_x;
	logic signed [AW-1:0] cb_z;
	side_t                cb_side;
	side_t                side_n1;

	ikin_cordic u_cordic_base (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(s_tvalid),
		.in_x(CW'(in_x) <<< 8),
		.in_y(CW'(in_y) <<< 8),
		.in_side(in_side),
		.out_valid(cb_valid), .out_x(cb_x), .out_z(cb_z), .out_side(cb_side)
	);

	always_comb begin
		side_n1    = cb_side;
		side_n1.t1 = to_q13(ZW'(cb_z));
	end

	logic          vld_s1;
	logic [MW-1:0] rxy_s1;
	side_t         side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= cb_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rxy_s1  <= gain(cb_x[29:0]);
			side_s1 <= side_n1;
		end
	end

	// distance in the arm plane
	logic                 cp_valid;
	logic signed [CW-1:0] cp_x;
	logic signed [AW-1:0] cp_z;
	side_t                cp_side;

	ikin_cordic u_cordic_plane (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s1),
		.in_x($signed(CW'(rxy_s1))),
		.in_y(CW'(side_s1.zeff) <<< 8),
		.in_side(side_s1),
		.out_valid(cp_valid), .out_x(cp_x), .out_z(cp_z), .out_side(cp_side)
	);

	logic          vld_s2, vld_s3, vld_s4, vld_s5;
	logic [MW-1:0] r_s2;
	logic [57:0]   rr_s3;
	logic signed [NW-1:0] num_s4;
	logic [RW-1:0] rem_s5;
	side_t         side_s2, side_s3, side_s4, side_s5;
	side_t         side_n2, side_n3, side_n5;
	logic signed [NW-1:0] den_ext;

	assign den_ext = $signed(NW'(den_q));

	always_comb begin
		side_n2         = cp_side;
		side_n2.a_plane = cp_z;

		side_n3     = side_s2;
		side_n3.oor = (26'(r_s2) < rmin_q && r_s2 < MW'(rmin_q)) ||
			(MW'(r_s2) > MW'(rmax_q));

		side_n5      = side_s4;
		side_n5.cpos = (den_q == '0) || (num_s4 >= den_ext);
		side_n5.cneg = (num_s4 <= -den_ext);
		side_n5.nneg = num_s4 < 0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s2 <= cp_valid;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2    <= gain(cp_x[29:0]);
			side_s2 <= side_n2;

			rr_s3   <= 58'(r_s2) * 58'(r_s2);
			side_s3 <= side_n3;

			num_s4  <= $signed(NW'(rr_s3)) - $signed(NW'(lsq_q));
			side_s4 <= side_s3;

			side_s5 <= side_n5;
			rem_s5  <= (num_s4 < 0) ? RW'(-num_s4) : RW'(num_s4);
		end
	end

	// elbow cosine
	logic          dv_valid;
	logic [QW-1:0] dv_q;
	side_t         dv_side;
	side_t         side_n6;

	ikin_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s5), .in_rem(rem_s5), .den(den_q), .in_side(side_s5),
		.out_valid(dv_valid), .out_q(dv_q), .out_side(dv_side)
	);

	always_comb begin
		side_n6 = dv_side;
		if (dv_side.cpos) begin
			side_n6.c = CV'(1) << 30;
		end else if (dv_side.cneg) begin
			side_n6.c = -(CV'(1) << 30);
		end else if (dv_side.nneg) begin
			side_n6.c = -$signed(CV'(dv_q));
		end else begin
			side_n6.c = $signed(CV'(dv_q));
		end
	end

	logic           vld_s6, vld_s7, vld_s8;
	side_t          side_s6, side_s7, side_s8;
	logic [SQW-1:0] csq_s7, v_s8;
	logic signed [63:0] csq_full;

	assign csq_full = side_s6.c * side_s6.c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s6 <= dv_valid;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= side_n6;

			csq_s7  <= SQW'(csq_full);
			side_s7 <= side_s6;

			v_s8    <= (SQW'(1) << 60) - csq_s7;
			side_s8 <= side_s7;
		end
	end

	// elbow sine
	logic          sq_valid;
	logic [SW-1:0] sq_s;
	side_t         sq_side;

	ikin_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s8), .in_v(v_s8), .in_side(side_s8),
		.out_valid(sq_valid), .out_s(sq_s), .out_side(sq_side)
	);

	logic                 vld_s9, vld_s10;
	logic signed [50:0]   lc_s9;
	logic [48:0]          ls_s9;
	logic [SW-1:0]        s_s9;
	side_t                side_s9, side_s10;
	logic signed [CW-1:0] ox_s10, oy_s10, ex_s10, ey_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s9  <= sq_valid;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lc_s9   <= $signed({1'b0, l2_q}) * sq_side.c;
			ls_s9   <= 49'(l2_q) * 49'(sq_s);
			s_s9    <= sq_s;
			side_s9 <= sq_side;

			ox_s10   <= ($signed(CW'(l1_q)) <<< 30) + CW'(lc_s9);
			oy_s10   <= $signed(CW'(ls_s9));
			ex_s10   <= CW'(side_s9.c);
			ey_s10   <= $signed(CW'(s_s9));
			side_s10 <= side_s9;
		end
	end

	// elbow angle and shoulder offset side by side
	logic                 ce_valid, co_valid;
	logic signed [AW-1:0] ce_z, co_z;
	side_t                co_side;

	ikin_cordic u_cordic_elbow (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s10), .in_x(ex_s10), .in_y(ey_s10), .in_side(side_s10),
		.out_valid(ce_valid), .out_x(), .out_z(ce_z), .out_side()
	);

	ikin_cordic u_cordic_offset (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s10), .in_x(ox_s10), .in_y(oy_s10), .in_side(side_s10),
		.out_valid(co_valid), .out_x(), .out_z(co_z), .out_side(co_side)
	);

	// limits and output register
	logic signed [ZW-1:0] diff;
	logic signed [TW-1:0] t1, t2, t3;
	logic                 lim;
	logic                 out_valid_q;
	logic [16:0]          base_q, shld_q, elbow_q;
	status_t              status_q;

	assign diff = ZW'(co_side.a_plane) - ZW'(co_z);
	assign t1   = co_side.t1;
	assign t2   = to_q13(diff);
	assign t3   = to_q13(ZW'(ce_z));
	assign lim  = (t1 < bmin_q) || (t1 > bmax_q) || (t2 < smin_q) || (t2 > smax_q) ||
		(t3 < emin_q) || (t3 > emax_q);

	assign en = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= co_valid && ce_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_q <= t1[16:0];
			if (co_side.oor) begin
				shld_q   <= '0;
				elbow_q  <= '0;
				status_q <= STATUS_REACH;
			end else begin
				shld_q   <= t2[16:0];
				elbow_q  <= t3[16:0];
				status_q <= lim ? STATUS_LIMIT : STATUS_OK;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, elbow_q, shld_q, base_q};
	assign m_tuser  = status_q;

endmodule
